@@ design/gspl_pkg.sv @@
// Shared types and constants for the gas sensor pollution level block.
package gspl_pkg;

  localparam int WINDOW_SAMPLES = 25;

  localparam int ADC_W  = 12;
  localparam int TEMP_W = 11;
  localparam int HUM_W  = 10;
  localparam int SUM_W  = 20;
  localparam int CNT_W  = 8;
  localparam int BASE_W = 18;
  localparam int LOAD_W = 16;
  localparam int RFS_W  = 16;
  localparam int PCT_W  = 14;
  localparam int RES_W  = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_R0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RFS     = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = 18'd18000;
  localparam logic [LOAD_W-1:0] LOAD_RESET = 16'd5000;
  localparam logic [RFS_W-1:0]  RFS_RESET  = 16'd19661;

  localparam logic [SUM_W-1:0] FULL_SCALE = SUM_W'(4095 * WINDOW_SAMPLES);
  localparam logic [CNT_W:0]   WIN_CNT    = (CNT_W + 1)'(WINDOW_SAMPLES);

  // R0 factor numerator k, in thousandths
  localparam int K_W    = 14;
  localparam int KMAG_W = 13;
  localparam logic signed [K_W-1:0] K_BASE    = 14'sd2050;
  localparam logic signed [K_W-1:0] K_UNCOMP  = 14'sd1000;

  localparam int MUL_A_W = 38;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int PLD_W  = 36;  // load * diff
  localparam int AQ_W   = 46;  // load * diff * 1000
  localparam int SB_W   = 38;  // sum * base
  localparam int BQ_W   = 51;  // sum * base * k
  localparam int PNUM_W = 30;  // (1 - ratio) * 10000
  localparam int Q16_W  = 16;

  localparam int NUM_W  = 62;
  localparam int DEN_W  = 51;
  localparam int QUO_W  = 25;
  localparam int QBIT_W = 5;
  localparam int DSH_W  = DEN_W + QUO_W - 1;

  // Top quotient bit of each division; a set top bit means saturation.
  localparam int QB_RES = 24;
  localparam int QB_RAT = 16;
  localparam int QB_PCT = 14;

  localparam logic [MUL_B_W-1:0] SCALE_MILLI = 20'd1000;
  localparam logic [MUL_B_W-1:0] PCT_SCALE   = 20'd10000;
  localparam logic [Q16_W:0]     ONE_Q16     = 17'h10000;
  localparam logic [PCT_W-1:0]   PCT_MAX     = 14'd10000;
  localparam logic [RES_W-1:0]   RES_MAX     = 24'hFFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LD,
    ST_MUL_A,
    ST_MUL_SB,
    ST_MUL_B,
    ST_RES_LD,
    ST_RES_DIV,
    ST_CHECK,
    ST_RAT_LD,
    ST_RAT_DIV,
    ST_MUL_PCT,
    ST_PCT_LD,
    ST_PCT_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [QBIT_W-1:0] top_bit;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/gspl_mul.sv @@
// Shared unsigned multiplier used by the window-end sequencer.
module gspl_mul (
  input  logic [gspl_pkg::MUL_A_W-1:0] a_i,
  input  logic [gspl_pkg::MUL_B_W-1:0] b_i,
  output logic [gspl_pkg::MUL_P_W-1:0] p_o
);
  import gspl_pkg::*;

  assign p_o = MUL_P_W'(a_i) * MUL_P_W'(b_i);

endmodule

@@ design/gspl_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
module gspl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gspl_pkg::div_ctrl_t         ctrl_i,
  input  logic [gspl_pkg::NUM_W-1:0]  num_i,
  input  logic [gspl_pkg::DEN_W-1:0]  den_i,
  output gspl_pkg::div_stat_t         stat_o,
  output logic [gspl_pkg::QUO_W-1:0]  quo_o
);
  import gspl_pkg::*;

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [QBIT_W-1:0] bit_q, bit_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;

  assign fits = {{(DSH_W - NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    bit_d  = bit_q;
    quo_d  = quo_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d  = num_i;
      dsh_d  = DSH_W'(den_i) << ctrl_i.top_bit;
      bit_d  = ctrl_i.top_bit;
      quo_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d        = rem_q - dsh_q[NUM_W-1:0];
        quo_d[bit_q] = 1'b1;
      end
      dsh_d = dsh_q >> 1;
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    bit_q <= bit_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

@@ design/gas_sensor_pollution_level_top.sv @@
// Top level: sample window accumulator and window-end Rs/R0 sequencer.
//
// Input channel (in_valid_i / in_stall_o): one ADC sample with climate fields per
// item. Items that do not close the window are summed and the block is ready
// again at once. The item that brings the count to WINDOW_SAMPLES starts the
// window-end sequence; in_stall_o stays high until its result is loaded into the
// output register, through the multiplies, up to three divisions of 25, 17 and
// 15 steps on the shared divider, and the load and check states. A zero sum or a
// degenerate R0 skips the later divisions and finishes earlier.
// Output channel (out_valid_o / out_stall_i): one result item per window, held in
// an output register. While the receiver stalls, the held item stays and new
// samples are still summed; only a finished window waits for the register.
// Configuration (cfg_valid_i / cfg_ready_o): always ready; write only when idle.
// Reset clears the window sum and count, loads the register defaults and empties
// the output register.
module gas_sensor_pollution_level_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gspl_pkg::ADC_W-1:0]        adc_sample_i,
  input  logic signed [gspl_pkg::TEMP_W-1:0] temperature_tenths_i,
  input  logic [gspl_pkg::HUM_W-1:0]        humidity_tenths_i,
  input  logic                              climate_valid_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gspl_pkg::PCT_W-1:0]        pollution_hundredths_o,
  output logic [gspl_pkg::RES_W-1:0]        gas_resistance_ohms_o,
  output logic                              compensated_o,
  output logic                              zero_reading_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gspl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gspl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gspl_pkg::*;

  state_e state_q, state_d;

  logic [BASE_W-1:0] base_q;
  logic [LOAD_W-1:0] load_q;
  logic [RFS_W-1:0]  rfs_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [SUM_W-1:0]        win_q, win_d;
  logic [SUM_W-1:0]        diff_q, diff_d;
  logic signed [K_W-1:0]   k_q, k_d;
  logic                    valid_q, valid_d;
  logic                    zero_q, zero_d;
  logic [PLD_W-1:0]        pld_q, pld_d;
  logic [AQ_W-1:0]         a_q, a_d;
  logic [BQ_W-1:0]         b_q, b_d;
  logic [Q16_W-1:0]        ratio_q, ratio_d;
  logic [PNUM_W-1:0]       pnum_q, pnum_d;
  logic [RES_W-1:0]        res_q, res_d;
  logic [PCT_W-1:0]        pct_q, pct_d;

  logic             out_valid_q, out_valid_d;
  logic [PCT_W-1:0] out_pct_q, out_pct_d;
  logic [RES_W-1:0] out_res_q, out_res_d;
  logic             out_comp_q, out_comp_d;
  logic             out_zero_q, out_zero_d;

  logic                   in_acc;
  logic                   out_free;
  logic [SUM_W-1:0]       sum_nx;
  logic [CNT_W:0]         cnt_nx;
  logic                   win_end;
  logic                   special;
  logic signed [K_W-1:0]  temp_ext;
  logic signed [K_W-1:0]  hum_ext;
  logic signed [K_W-1:0]  k_comp;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [QUO_W-1:0]   div_quo;

  gspl_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  gspl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sum_nx     = sum_q + SUM_W'(adc_sample_i);
  assign cnt_nx     = {1'b0, cnt_q} + 1'b1;
  assign win_end    = cnt_nx >= WIN_CNT;
  assign special    = (base_q == '0) || (k_q == '0) || k_q[K_W-1] || zero_q;

  assign temp_ext = {{(K_W - TEMP_W){temperature_tenths_i[TEMP_W-1]}}, temperature_tenths_i};
  assign hum_ext  = $signed({{(K_W - HUM_W){1'b0}}, humidity_tenths_i});
  assign k_comp   = K_BASE - (temp_ext <<< 1) - hum_ext;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc && win_end) state_d = ST_MUL_LD;
      ST_MUL_LD:  state_d = ST_MUL_A;
      ST_MUL_A:   state_d = ST_MUL_SB;
      ST_MUL_SB:  state_d = ST_MUL_B;
      ST_MUL_B:   state_d = zero_q ? ST_CHECK : ST_RES_LD;
      ST_RES_LD:  state_d = ST_RES_DIV;
      ST_RES_DIV: if (div_stat.done) state_d = ST_CHECK;
      ST_CHECK:   state_d = special ? ST_OUT : ST_RAT_LD;
      ST_RAT_LD:  state_d = ST_RAT_DIV;
      ST_RAT_DIV: if (div_stat.done) state_d = div_quo[QB_RAT] ? ST_OUT : ST_MUL_PCT;
      ST_MUL_PCT: state_d = ST_PCT_LD;
      ST_PCT_LD:  state_d = ST_PCT_DIV;
      ST_PCT_DIV: if (div_stat.done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_ctrl = '0;
    div_num  = '0;
    div_den  = '0;

    sum_d   = sum_q;
    cnt_d   = cnt_q;
    win_d   = win_q;
    diff_d  = diff_q;
    k_d     = k_q;
    valid_d = valid_q;
    zero_d  = zero_q;
    pld_d   = pld_q;
    a_d     = a_q;
    b_d     = b_q;
    ratio_d = ratio_q;
    pnum_d  = pnum_q;
    res_d   = res_q;
    pct_d   = pct_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_pct_d   = out_pct_q;
    out_res_d   = out_res_q;
    out_comp_d  = out_comp_q;
    out_zero_d  = out_zero_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!win_end) begin
            sum_d = sum_nx;
            cnt_d = cnt_nx[CNT_W-1:0];
          end else begin
            sum_d   = '0;
            cnt_d   = '0;
            win_d   = sum_nx;
            diff_d  = (sum_nx <= FULL_SCALE) ? FULL_SCALE - sum_nx : '0;
            k_d     = climate_valid_i ? k_comp : K_UNCOMP;
            valid_d = climate_valid_i;
            zero_d  = (sum_nx == '0);
          end
        end
      end
      ST_MUL_LD: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = MUL_B_W'(load_q);
        pld_d = mul_p[PLD_W-1:0];
      end
      ST_MUL_A: begin
        mul_a = MUL_A_W'(pld_q);
        mul_b = SCALE_MILLI;
        a_d   = mul_p[AQ_W-1:0];
      end
      ST_MUL_SB: begin
        mul_a = MUL_A_W'(base_q);
        mul_b = MUL_B_W'(win_q);
        b_d   = BQ_W'(mul_p[SB_W-1:0]);
      end
      ST_MUL_B: begin
        // k only matters here when positive
        mul_a = b_q[SB_W-1:0];
        mul_b = MUL_B_W'(k_q[KMAG_W-1:0]);
        b_d   = mul_p[BQ_W-1:0];
        if (zero_q) res_d = RES_MAX;
      end
      ST_RES_LD: begin
        div_ctrl.start   = 1'b1;
        div_ctrl.top_bit = QBIT_W'(QB_RES);
        div_num          = NUM_W'(pld_q);
        div_den          = DEN_W'(win_q);
      end
      ST_RES_DIV: begin
        if (div_stat.done) res_d = div_quo[QB_RES] ? RES_MAX : div_quo[RES_W-1:0];
      end
      ST_CHECK: begin
        priority if ((base_q == '0) || (k_q == '0)) pct_d = '0;
        else if (k_q[K_W-1])                        pct_d = PCT_MAX;
        else if (zero_q)                            pct_d = '0;
        else                                        pct_d = pct_q;
      end
      ST_RAT_LD: begin
        div_ctrl.start   = 1'b1;
        div_ctrl.top_bit = QBIT_W'(QB_RAT);
        div_num          = {a_q, {Q16_W{1'b0}}};
        div_den          = b_q;
      end
      ST_RAT_DIV: begin
        if (div_stat.done) begin
          ratio_d = div_quo[Q16_W-1:0];
          if (div_quo[QB_RAT]) pct_d = '0;  // ratio at or above 1.0
        end
      end
      ST_MUL_PCT: begin
        mul_a  = MUL_A_W'(ONE_Q16 - {1'b0, ratio_q});
        mul_b  = PCT_SCALE;
        pnum_d = mul_p[PNUM_W-1:0];
      end
      ST_PCT_LD: begin
        div_ctrl.start   = 1'b1;
        div_ctrl.top_bit = QBIT_W'(QB_PCT);
        div_num          = NUM_W'(pnum_q);
        div_den          = DEN_W'(ONE_Q16 - {1'b0, rfs_q});
      end
      ST_PCT_DIV: begin
        if (div_stat.done) begin
          if (div_quo[QB_PCT] || (div_quo[PCT_W-1:0] > PCT_MAX)) pct_d = PCT_MAX;
          else                                                    pct_d = div_quo[PCT_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pct_d   = pct_q;
          out_res_d   = res_q;
          out_comp_d  = valid_q;
          out_zero_d  = zero_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    diff_q     <= diff_d;
    k_q        <= k_d;
    valid_q    <= valid_d;
    zero_q     <= zero_d;
    pld_q      <= pld_d;
    a_q        <= a_d;
    b_q        <= b_d;
    ratio_q    <= ratio_d;
    pnum_q     <= pnum_d;
    res_q      <= res_d;
    pct_q      <= pct_d;
    out_pct_q  <= out_pct_d;
    out_res_q  <= out_res_d;
    out_comp_q <= out_comp_d;
    out_zero_q <= out_zero_d;
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      load_q <= LOAD_RESET;
      rfs_q  <= RFS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_BASE_R0) base_q <= cfg_data_i[BASE_W-1:0];
      if (cfg_index_i == CFG_LOAD)    load_q <= cfg_data_i[LOAD_W-1:0];
      if (cfg_index_i == CFG_RFS)     rfs_q  <= cfg_data_i[RFS_W-1:0];
    end
  end

  assign out_valid_o            = out_valid_q;
  assign pollution_hundredths_o = out_pct_q;
  assign gas_resistance_ohms_o  = out_res_q;
  assign compensated_o          = out_comp_q;
  assign zero_reading_o         = out_zero_q;

endmodule

@@ test/gspl_reading_checker.sv @@
// Checker: predicts each window's pollution reading and compares it with the block's output.
module gspl_reading_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [gspl_pkg::ADC_W-1:0]         adc_sample_i,
  input  logic signed [gspl_pkg::TEMP_W-1:0] temperature_tenths_i,
  input  logic [gspl_pkg::HUM_W-1:0]         humidity_tenths_i,
  input  logic                               climate_valid_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [gspl_pkg::PCT_W-1:0]         pollution_hundredths_i,
  input  logic [gspl_pkg::RES_W-1:0]         gas_resistance_ohms_i,
  input  logic                               compensated_i,
  input  logic                               zero_reading_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [gspl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gspl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 pending_o,
  output int                                 errors_o
);
  import gspl_pkg::*;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [RES_W-1:0] res;
    logic             comp;
    logic             zero;
  } reading_t;

  logic [BASE_W-1:0] base_r0;
  logic [LOAD_W-1:0] load_r;
  logic [RFS_W-1:0]  rfs_r;
  logic [SUM_W-1:0]  win_sum;
  logic [CNT_W-1:0]  win_cnt;
  logic [SUM_W-1:0]  sum_next;
  reading_t          reading_q[$];
  reading_t          want;

  function automatic reading_t predict_reading(input logic [SUM_W-1:0] sum,
                                               input logic signed [TEMP_W-1:0] temp,
                                               input logic [HUM_W-1:0] hum,
                                               input logic cv);
    reading_t r;
    longint k;
    bit [63:0] diff, rs, num, den, ratio, pnum, pct;
    k = cv ? (longint'(K_BASE) - 2 * longint'(temp) - longint'(hum)) : longint'(K_UNCOMP);
    diff = (sum <= FULL_SCALE) ? 64'(FULL_SCALE - sum) : 64'd0;
    r.zero = (sum == '0);
    r.comp = cv;
    if (r.zero) begin
      rs = 64'(RES_MAX);
    end else begin
      rs = 64'(load_r) * diff / 64'(sum);
      if (rs > 64'(RES_MAX)) rs = 64'(RES_MAX);
    end
    r.res = rs[RES_W-1:0];
    // degenerate R0 wins over the zero-sum rule
    if (base_r0 == '0 || k == 0) begin
      pct = 0;
    end else if (k < 0) begin
      pct = 64'(PCT_MAX);
    end else if (r.zero) begin
      pct = 0;
    end else begin
      num = 64'(load_r) * diff * 64'(SCALE_MILLI) * 64'(ONE_Q16);
      den = 64'(sum) * 64'(base_r0) * 64'(k);
      ratio = num / den;
      if (ratio >= 64'(ONE_Q16)) begin
        pct = 0;
      end else begin
        pnum = (64'(ONE_Q16) - ratio) * 64'(PCT_SCALE);
        pct = pnum / (64'(ONE_Q16) - 64'(rfs_r));
        if (pct > 64'(PCT_MAX)) pct = 64'(PCT_MAX);
      end
    end
    r.pct = pct[PCT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned wanted);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, seen, wanted);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_r0 = BASE_RESET;
      load_r = LOAD_RESET;
      rfs_r = RFS_RESET;
      win_sum = '0;
      win_cnt = '0;
      reading_q.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BASE_R0: base_r0 = cfg_data_i[BASE_W-1:0];
          CFG_LOAD:    load_r = cfg_data_i[LOAD_W-1:0];
          CFG_RFS:     rfs_r = cfg_data_i[RFS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          report_mismatch("unexpected item, pollution_hundredths", pollution_hundredths_i, 0);
        end else begin
          want = reading_q.pop_front();
          if (pollution_hundredths_i !== want.pct)
            report_mismatch("pollution_hundredths", pollution_hundredths_i, want.pct);
          if (gas_resistance_ohms_i !== want.res)
            report_mismatch("gas_resistance_ohms", gas_resistance_ohms_i, want.res);
          if (compensated_i !== want.comp)
            report_mismatch("compensated", compensated_i, want.comp);
          if (zero_reading_i !== want.zero)
            report_mismatch("zero_reading", zero_reading_i, want.zero);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        sum_next = win_sum + SUM_W'(adc_sample_i);
        if (int'(win_cnt) + 1 < WINDOW_SAMPLES) begin
          win_sum = sum_next;
          win_cnt = win_cnt + 1'b1;
        end else begin
          // climate fields of the closing sample decide the compensation
          reading_q.push_back(predict_reading(sum_next, temperature_tenths_i,
                                              humidity_tenths_i, climate_valid_i));
          win_sum = '0;
          win_cnt = '0;
        end
      end

      pending_o <= reading_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top: drives samples, register writes and output stalls, and gives the verdict.
module tb;
  import gspl_pkg::*;

  localparam int LATENCY_WAIT = 100;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES = 7;
  localparam int WINDOWS_PER_PHASE = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ADC_W-1:0]         adc_sample_i;
  logic signed [TEMP_W-1:0] temperature_tenths_i;
  logic [HUM_W-1:0]         humidity_tenths_i;
  logic                     climate_valid_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [PCT_W-1:0]         pollution_hundredths_o;
  logic [RES_W-1:0]         gas_resistance_ohms_o;
  logic                     compensated_o;
  logic                     zero_reading_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  int   pending;
  int   errors;
  int   idle_cycles;
  logic steady_phase;

  gas_sensor_pollution_level_top dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .adc_sample_i           (adc_sample_i),
    .temperature_tenths_i   (temperature_tenths_i),
    .humidity_tenths_i      (humidity_tenths_i),
    .climate_valid_i        (climate_valid_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .pollution_hundredths_o (pollution_hundredths_o),
    .gas_resistance_ohms_o  (gas_resistance_ohms_o),
    .compensated_o          (compensated_o),
    .zero_reading_o         (zero_reading_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  gspl_reading_checker checker_i (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .adc_sample_i           (adc_sample_i),
    .temperature_tenths_i   (temperature_tenths_i),
    .humidity_tenths_i      (humidity_tenths_i),
    .climate_valid_i        (climate_valid_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .pollution_hundredths_i (pollution_hundredths_o),
    .gas_resistance_ohms_i  (gas_resistance_ohms_o),
    .compensated_i          (compensated_o),
    .zero_reading_i         (zero_reading_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .pending_o              (pending),
    .errors_o               (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic int pick_reg(input int maxv, input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return maxv;
    if (r == 3) return $urandom_range(0, maxv);
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_sample(input logic [ADC_W-1:0] s, input logic signed [TEMP_W-1:0] t,
                             input logic [HUM_W-1:0] h, input logic c);
    int gap;
    in_valid_i <= 1'b1;
    adc_sample_i <= s;
    temperature_tenths_i <= t;
    humidity_tenths_i <= h;
    climate_valid_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_window(input int s, input int t, input int h, input logic c);
    int i;
    for (i = 0; i < WINDOW_SAMPLES; i++)
      send_sample(ADC_W'(s), TEMP_W'(t), HUM_W'(h), c);
  endtask

  task automatic send_random_window(input int count);
    int mode, centre, i, v;
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0] h;
    logic c;
    mode = $urandom_range(0, 99);
    centre = $urandom_range(0, 4095);
    for (i = 0; i < count; i++) begin
      if (mode < 8) v = 0;
      else if (mode < 14) v = 4095;
      else if (mode < 30) v = $urandom_range(0, 4095);
      else begin
        v = centre + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      if ($urandom_range(0, 9) == 0) begin
        t = TEMP_W'($urandom);
        h = HUM_W'($urandom);
      end else begin
        t = TEMP_W'(int'($urandom_range(0, 1250)) - 400);
        h = HUM_W'($urandom_range(0, 1000));
      end
      c = ($urandom_range(0, 3) != 0);
      send_sample(ADC_W'(v), t, h, c);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure_phase(input int p);
    logic [BASE_W-1:0] b;
    logic [LOAD_W-1:0] l;
    logic [RFS_W-1:0]  f;
    case (p)
      1: begin
        b = '1; l = '1; f = '1;
      end
      2: begin
        b = 1; l = 1; f = 1;
      end
      3: begin
        b = '0; l = '0; f = '0;
      end
      default: begin
        b = BASE_W'(pick_reg(262143, 2000, 60000));
        l = LOAD_W'(pick_reg(65535, 500, 20000));
        f = RFS_W'(pick_reg(65535, 5000, 60000));
      end
    endcase
    // upper data bits beyond a 16-bit register are don't-care
    write_reg(CFG_BASE_R0, CFG_DATA_W'(b));
    write_reg(CFG_LOAD, {2'($urandom), l});
    write_reg(CFG_RFS, {2'($urandom), f});
    if ($urandom_range(0, 1) != 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  initial begin : stall_gen
    int hold, r;
    out_stall_i <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(0, 20);
        end else if (r < 55) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(100, 400);
        end else if (r < 93) begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (r < 98) begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(10, 60);
        end else begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(100, 200);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p, w, i, extra;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    adc_sample_i <= '0;
    temperature_tenths_i <= '0;
    humidity_tenths_i <= '0;
    climate_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_BASE_R0;
    cfg_data_i <= '0;
    steady_phase = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows on reset register values
    send_window(0, 200, 650, 1'b1);      // zero sum
    send_window(4095, 0, 0, 1'b0);       // full-scale sum, Rs zero
    send_window(2000, 850, 1000, 1'b1);  // negative R0
    send_window(2000, 525, 1000, 1'b1);  // R0 exactly zero
    send_window(2000, -1024, 0, 1'b1);   // coldest code, largest R0
    send_window(1500, 1023, 1023, 1'b1); // largest positive climate codes
    send_window(0, 850, 1000, 1'b1);     // zero sum with negative R0
    send_window(60, -400, 0, 1'b0);      // ratio above one
    for (i = 0; i < WINDOW_SAMPLES; i++)
      send_sample((i % 2) ? ADC_W'(4095) : ADC_W'(0), TEMP_W'($urandom),
                  HUM_W'($urandom), 1'($urandom));
    in_valid_i <= 1'b0;

    for (p = 1; p <= PHASES; p++) begin
      wait_drained();
      configure_phase(p);
      steady_phase = ($urandom_range(0, 3) == 0);
      for (w = 0; w < WINDOWS_PER_PHASE; w++) send_random_window(WINDOW_SAMPLES);
      // leave a partial window open across the next register change
      extra = $urandom_range(0, WINDOW_SAMPLES - 1);
      if (extra > 0) send_random_window(extra);
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
